>>> hw/rtl/neighborhood_relative_drop_marker_top_macros.svh
// Assertion macros used by the top RTL file of the relative drop marker.
// Each macro takes a label, an antecedent and a consequent, and is
// clocked by clk_i and disabled while rst_ni is low.
`ifndef NEIGHBORHOOD_RELATIVE_DROP_MARKER_TOP_MACROS_SVH
`define NEIGHBORHOOD_RELATIVE_DROP_MARKER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define NRDM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nrdm assertion failed");
// Next-cycle implication.
`define NRDM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nrdm assertion failed");
`else
`define NRDM_ASSERT_IMP(lbl, ante, cons)
`define NRDM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/nrdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nrdm_pkg;

  // Field widths.
  localparam int PIXEL_W        = 16;
  localparam int LINE_WIDTH_W   = 9;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int PERCENT_W      = 7;
  localparam int MARK_W         = 8;
  localparam int OUT_ROW_W      = 12;
  localparam int OUT_COL_W      = 8;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 13;

  // Default sizes of the line store and of the row counter range.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Register reset values.
  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = LINE_WIDTH_W'(256);
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = FRAME_HEIGHT_W'(256);
  localparam logic [PERCENT_W-1:0]      PERCENT_RST      = PERCENT_W'(10);

  // Mark written for a pixel that drops against some neighbor.
  localparam logic [MARK_W-1:0] MARK_VALUE = MARK_W'(200);

  // Scale of the threshold: the difference is weighed against percent/100.
  localparam int PERCENT_SCALE = 100;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LINE_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_PERCENT      = 2'd2
  } cfg_idx_e;

  // Per-pixel bookkeeping that travels alongside the pixel through the pipe.
  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
  } tag_t;

  // 3x3 window, [row][col], row 0 is the oldest line, col 2 the newest pixel.
  typedef logic [2:0][2:0][PIXEL_W-1:0] win_t;

endpackage

`default_nettype wire

>>> hw/rtl/nrdm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM with registered, read-first output.
module nrdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/nrdm_window.sv
`timescale 1ns / 1ps
`default_nettype none

// Two line stores and the 3x3 window. Stage 1 holds the pixel while the
// line stores are read; stage 2 holds the shifted window for judging.
module nrdm_window import nrdm_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               accept_i,
  input  logic [PIXEL_W-1:0] pixel_i,
  input  logic [ColW-1:0]    col_i,
  input  tag_t               tag_i,
  output win_t               win_o,
  output logic               valid_o,
  output tag_t               tag_o
);

  logic [PIXEL_W-1:0] above1_rdata;
  logic [PIXEL_W-1:0] above2_rdata;
  logic [PIXEL_W-1:0] above2;

  logic               v1_q;
  logic [PIXEL_W-1:0] px1_q;
  logic [ColW-1:0]    k1_q;
  tag_t               tag1_q;
  logic               fwd_q;
  logic [PIXEL_W-1:0] fwd_data_q;

  win_t               win_q, win_d;
  logic               v2_q;
  tag_t               tag2_q;

  logic               adv1;

  assign adv1 = en_i && v1_q;

  // Newest line: written with the incoming pixel as it is read.
  nrdm_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_line1 (
    .clk_i  (clk_i),
    .we_i   (accept_i),
    .waddr_i(col_i),
    .wdata_i(pixel_i),
    .re_i   (accept_i),
    .raddr_i(col_i),
    .rdata_o(above1_rdata)
  );

  // Older line: takes the value read from the newest line as stage 1 advances.
  nrdm_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_line2 (
    .clk_i  (clk_i),
    .we_i   (adv1),
    .waddr_i(k1_q),
    .wdata_i(above1_rdata),
    .re_i   (accept_i),
    .raddr_i(col_i),
    .rdata_o(above2_rdata)
  );

  // A read of the older line at the address that stage 1 writes in the
  // same cycle misses that write, so the value is passed along directly.
  assign above2 = fwd_q ? fwd_data_q : above2_rdata;

  always_comb begin
    win_d = win_q;
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = above2;
    win_d[1][2] = above1_rdata;
    win_d[2][2] = px1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      win_q <= '0;
    end else if (en_i) begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      if (v1_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      px1_q      <= pixel_i;
      k1_q       <= col_i;
      tag1_q     <= tag_i;
      fwd_q      <= v1_q && (col_i == k1_q);
      fwd_data_q <= above1_rdata;
    end
    if (adv1) begin
      tag2_q <= tag1_q;
    end
  end

  assign win_o   = win_q;
  assign valid_o = v2_q;
  assign tag_o   = tag2_q;

endmodule

`default_nettype wire

>>> hw/rtl/nrdm_judge.sv
`timescale 1ns / 1ps
`default_nettype none

// Nine parallel tests of 100*(center - neighbor) >= percent*center.
module nrdm_judge import nrdm_pkg::*; (
  input  win_t                 win_i,
  input  logic [PERCENT_W-1:0] percent_i,
  output logic [MARK_W-1:0]    mark_o
);

  localparam int ProdW = PIXEL_W + PERCENT_W + 2;

  logic signed [PIXEL_W-1:0] ctr;
  logic signed [ProdW-1:0]   rhs;
  logic signed [ProdW-1:0]   diff [9];
  logic [8:0]                hit;

  assign ctr = $signed(win_i[1][1]);
  assign rhs = ProdW'($signed({1'b0, percent_i})) * ProdW'(ctr);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        diff[3*i+j] = ProdW'(ctr) - ProdW'($signed(win_i[i][j]));
        hit[3*i+j]  = (diff[3*i+j] * ProdW'(PERCENT_SCALE)) >= rhs;
      end
    end
  end

  assign mark_o = (|hit) ? MARK_VALUE : '0;

endmodule

`default_nettype wire

>>> hw/rtl/neighborhood_relative_drop_marker_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "neighborhood_relative_drop_marker_top_macros.svh"

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   pixel_i, frame_first_i
// out       output     out_valid_o / out_ready_i mark_o, out_row_o, out_col_o, last_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The block takes one pixel request per cycle unless the pipe holds; a result
// is offered once the pixel completing its window has passed the window stages
// and the result register. The rate is set by the nine parallel compares of the
// judge stage and by the single read of each line store per pixel. Reset is
// asynchronous and active low; the line stores need no clearing pass. When a
// result waits and out_ready_i is low, the whole pipe holds and in_ready_o
// drops; configuration is always taken.
module neighborhood_relative_drop_marker_top import nrdm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Pixel requests.
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [PIXEL_W-1:0]        pixel_i,
  input  logic                      frame_first_i,
  // Result requests.
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [MARK_W-1:0]         mark_o,
  output logic [OUT_ROW_W-1:0]      out_row_o,
  output logic [OUT_COL_W-1:0]      out_col_o,
  output logic                      last_o,
  // Register writes.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  // Counter widths follow the store size and frame height range; the limit
  // compares run wide enough for both the counter plus one and the register.
  localparam int ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WcmpW = (ColW + 1 > LINE_WIDTH_W) ? ColW + 1 : LINE_WIDTH_W;
  localparam int HcmpW = (RowW + 1 > FRAME_HEIGHT_W) ? RowW + 1 : FRAME_HEIGHT_W;

  // Configuration registers.
  logic [LINE_WIDTH_W-1:0]   line_width_q;
  logic [FRAME_HEIGHT_W-1:0] frame_height_q;
  logic [PERCENT_W-1:0]      percent_q;

  // Position of the next incoming pixel.
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [WcmpW-1:0] w_ext, w_lim, c_inc;
  logic [HcmpW-1:0] h_ext, h_lim, r_inc;
  logic [ColW-1:0]  c0, c_m1;
  logic [RowW-1:0]  r0, r_m1;
  logic [RowW+OUT_ROW_W-1:0] row_wide;
  logic [ColW+OUT_COL_W-1:0] col_wide;

  logic en, accept;
  tag_t tag0, tag2;
  win_t win;
  logic v2;
  logic [MARK_W-1:0] mark;

  // Result register.
  logic                 out_valid_q;
  logic [MARK_W-1:0]    mark_q;
  logic [OUT_ROW_W-1:0] out_row_q;
  logic [OUT_COL_W-1:0] out_col_q;
  logic                 last_q;

  // The pipe moves whenever the result register is empty or being emptied.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LINE_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      percent_q      <= PERCENT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_WIDTH:   line_width_q   <= cfg_data_i[LINE_WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FRAME_HEIGHT_W-1:0];
        CFG_PERCENT:      percent_q      <= cfg_data_i[PERCENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Limits in use: the registers clamped to three and to the store size (width) or row counter range (height).
  assign w_ext = WcmpW'(line_width_q);
  assign h_ext = HcmpW'(frame_height_q);

  always_comb begin
    if (w_ext < WcmpW'(3)) begin
      w_lim = WcmpW'(3);
    end else if (w_ext > WcmpW'(MAX_WIDTH)) begin
      w_lim = WcmpW'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    if (h_ext < HcmpW'(3)) begin
      h_lim = HcmpW'(3);
    end else if (h_ext > HcmpW'(MAX_HEIGHT)) begin
      h_lim = HcmpW'(MAX_HEIGHT);
    end else begin
      h_lim = h_ext;
    end
  end

  // A frame start restarts the position before the pixel is placed.
  assign c0 = frame_first_i ? '0 : col_q;
  assign r0 = frame_first_i ? '0 : row_q;

  assign c_inc = WcmpW'(c0) + WcmpW'(1);
  assign r_inc = HcmpW'(r0) + HcmpW'(1);

  always_comb begin
    col_d = c_inc[ColW-1:0];
    row_d = r0;
    if (c_inc >= w_lim) begin
      col_d = '0;
      row_d = r_inc[RowW-1:0];
      if (r_inc >= h_lim) begin
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // The pixel at (r, c) completes the window centered at (r-1, c-1).
  assign c_m1     = c0 - ColW'(1);
  assign r_m1     = r0 - RowW'(1);
  assign col_wide = {{OUT_COL_W{1'b0}}, c_m1};
  assign row_wide = {{OUT_ROW_W{1'b0}}, r_m1};

  always_comb begin
    tag0.emit = (r0 >= RowW'(2)) && (c0 >= ColW'(2));
    tag0.last = (HcmpW'(r0) == h_lim - HcmpW'(1)) && (WcmpW'(c0) == w_lim - WcmpW'(1));
    tag0.row  = row_wide[OUT_ROW_W-1:0];
    tag0.col  = col_wide[OUT_COL_W-1:0];
  end

  nrdm_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .accept_i(accept),
    .pixel_i (pixel_i),
    .col_i   (c0),
    .tag_i   (tag0),
    .win_o   (win),
    .valid_o (v2),
    .tag_o   (tag2)
  );

  nrdm_judge u_judge (
    .win_i    (win),
    .percent_i(percent_q),
    .mark_o   (mark)
  );

  // Border pixels pass through the pipe but leave no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v2 && tag2.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mark_q    <= mark;
      out_row_q <= tag2.row;
      out_col_q <= tag2.col;
      last_q    <= tag2.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mark_o      = mark_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign last_o      = last_q;

  // A frame start always leaves the position one step into the first row.
  `NRDM_ASSERT_NXT(a_frame_restart, accept && frame_first_i, (col_q == ColW'(1)) && (row_q == '0))
  // Only the two mark values ever leave the block.
  `NRDM_ASSERT_IMP(a_mark_values, out_valid_q, (mark_q == '0) || (mark_q == MARK_VALUE))
  // The last result of a frame sits in the last interior column.
  `NRDM_ASSERT_IMP(a_last_column, out_valid_q && last_q, out_col_q == OUT_COL_W'(w_lim - WcmpW'(2)))

endmodule

`default_nettype wire
